// ===== design/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
// Holds the status codes, the per-item result bundle and the queue sizing.
// No dependencies.
package jsu_pkg;

	typedef enum logic [3:0] {
		ST_RUNNING      = 4'd0,
		ST_CLOSED       = 4'd1,
		ST_UNTERMINATED = 4'd2,
		ST_CONTROL_CHAR = 4'd3,
		ST_BAD_UTF8     = 4'd4,
		ST_BAD_HEX      = 4'd5,
		ST_MISSING_LOW  = 4'd6,
		ST_LONE_LOW     = 4'd7,
		ST_BAD_ESCAPE   = 4'd8
	} status_t;

	// Everything one accepted input item produces: either 1..4 data bytes or
	// a single status result.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt_m1;
		logic            is_stat;
		status_t         stat;
	} bundle_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== design/jsu_front.sv =====
// Front end: accepts raw string bytes and runs the escape / UTF-8 scanner.
// Produces one result bundle per item that has results.
// Depends on jsu_pkg.
module jsu_front
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       bundle_push,
	output bundle_t    bundle
);

	typedef enum logic [2:0] {
		M_NORMAL, M_ESC, M_HEX1, M_SURR_BS, M_SURR_U, M_HEX2, M_UTF8
	} mode_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt_m1;
	} enc_t;

	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_FIRST = 21'h00D800;
	localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
	localparam logic [15:0] HI_FIRST   = 16'hD800;
	localparam logic [15:0] HI_LAST    = 16'hDBFF;
	localparam logic [15:0] LO_FIRST   = 16'hDC00;
	localparam logic [15:0] LO_LAST    = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h010000;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.bytes[0] = {1'b0, cp[6:0]};
			e.cnt_m1   = 2'd0;
		end else if (cp < 21'h800) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.cnt_m1   = 2'd1;
		end else if (cp < SUPP_BASE) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.cnt_m1   = 2'd2;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.cnt_m1   = 2'd3;
		end
		return e;
	endfunction

	mode_t           mode_q, mode_n;
	logic [15:0]     hex_accum_q, hex_accum_n;
	logic [1:0]      hex_count_q, hex_count_n;
	logic [15:0]     high_half_q, high_half_n;
	logic [3:0][7:0] seq_bytes_q;
	logic [2:0]      seq_length_q, seq_length_n;
	logic [2:0]      seq_count_q, seq_count_n;
	logic [20:0]     code_accum_q, code_accum_n;

	logic        seq_we;
	logic [1:0]  seq_widx;
	logic        fin;
	status_t     fin_code;
	logic        has_bytes;
	logic [4:0]  hd;
	logic [15:0] hex_new;
	logic [20:0] code_new;
	logic [20:0] cp_min;
	logic [20:0] cp_pair;
	enc_t        enc;
	bundle_t     b;

	always_comb begin
		mode_n       = mode_q;
		hex_accum_n  = hex_accum_q;
		hex_count_n  = hex_count_q;
		high_half_n  = high_half_q;
		seq_length_n = seq_length_q;
		seq_count_n  = seq_count_q;
		code_accum_n = code_accum_q;
		seq_we       = 1'b0;
		seq_widx     = seq_count_q[1:0];
		fin          = 1'b0;
		fin_code     = ST_UNTERMINATED;
		has_bytes    = 1'b0;
		b            = '0;
		b.stat       = ST_RUNNING;
		hd           = hex_digit(in_byte);
		hex_new      = {hex_accum_q[11:0], hd[3:0]};
		code_new     = {code_accum_q[14:0], in_byte[5:0]};
		cp_pair      = SUPP_BASE + {1'b0, high_half_q[9:0], hex_new[9:0]};
		cp_min       = (seq_length_q == 3'd2) ? 21'h80 :
		               (seq_length_q == 3'd3) ? 21'h800 : SUPP_BASE;
		enc          = encode({5'd0, hex_new});

		if (end_of_text) begin
			fin = 1'b1;
			if (mode_q == M_SURR_BS || mode_q == M_SURR_U) fin_code = ST_MISSING_LOW;
			else if (mode_q == M_UTF8) fin_code = ST_BAD_UTF8;
			else fin_code = ST_UNTERMINATED;
		end else begin
			unique case (mode_q)
				M_ESC: begin
					mode_n    = M_NORMAL;
					has_bytes = 1'b1;
					case (in_byte)
						8'h22: b.bytes[0] = 8'h22;
						8'h5C: b.bytes[0] = 8'h5C;
						8'h2F: b.bytes[0] = 8'h2F;
						8'h62: b.bytes[0] = 8'h08;
						8'h66: b.bytes[0] = 8'h0C;
						8'h6E: b.bytes[0] = 8'h0A;
						8'h72: b.bytes[0] = 8'h0D;
						8'h74: b.bytes[0] = 8'h09;
						8'h75: begin
							has_bytes   = 1'b0;
							mode_n      = M_HEX1;
							hex_accum_n = '0;
							hex_count_n = '0;
						end
						default: begin
							has_bytes = 1'b0;
							fin       = 1'b1;
							fin_code  = ST_BAD_ESCAPE;
						end
					endcase
				end
				M_HEX1, M_HEX2: begin
					if (!hd[4]) begin
						fin      = 1'b1;
						fin_code = ST_BAD_HEX;
					end else begin
						hex_accum_n = hex_new;
						hex_count_n = hex_count_q + 2'd1;
						if (hex_count_q == 2'd3) begin
							if (mode_q == M_HEX1) begin
								if (hex_new >= HI_FIRST && hex_new <= HI_LAST) begin
									high_half_n = hex_new;
									mode_n      = M_SURR_BS;
								end else if (hex_new >= LO_FIRST && hex_new <= LO_LAST) begin
									fin      = 1'b1;
									fin_code = ST_LONE_LOW;
								end else begin
									mode_n    = M_NORMAL;
									has_bytes = 1'b1;
									b.bytes   = enc.bytes;
									b.cnt_m1  = enc.cnt_m1;
								end
							end else begin
								if (hex_new < LO_FIRST || hex_new > LO_LAST) begin
									fin      = 1'b1;
									fin_code = ST_MISSING_LOW;
								end else begin
									enc       = encode(cp_pair);
									mode_n    = M_NORMAL;
									has_bytes = 1'b1;
									b.bytes   = enc.bytes;
									b.cnt_m1  = enc.cnt_m1;
								end
							end
						end
					end
				end
				M_SURR_BS: begin
					if (in_byte != 8'h5C) begin
						fin      = 1'b1;
						fin_code = ST_MISSING_LOW;
					end else begin
						mode_n = M_SURR_U;
					end
				end
				M_SURR_U: begin
					if (in_byte != 8'h75) begin
						fin      = 1'b1;
						fin_code = ST_MISSING_LOW;
					end else begin
						mode_n      = M_HEX2;
						hex_accum_n = '0;
						hex_count_n = '0;
					end
				end
				M_UTF8: begin
					if (in_byte[7:6] != 2'b10) begin
						fin      = 1'b1;
						fin_code = ST_BAD_UTF8;
					end else begin
						seq_we       = 1'b1;
						code_accum_n = code_new;
						seq_count_n  = seq_count_q + 3'd1;
						if (seq_count_n >= seq_length_q) begin
							if (code_new < cp_min || code_new > CP_MAX ||
							    (code_new >= SURR_FIRST && code_new <= SURR_LAST)) begin
								fin      = 1'b1;
								fin_code = ST_BAD_UTF8;
							end else begin
								has_bytes = 1'b1;
								for (int k = 0; k < 4; k++) begin
									b.bytes[k] = (k[1:0] == seq_count_q[1:0]) ?
									             in_byte : seq_bytes_q[k];
								end
								b.cnt_m1    = 2'(seq_length_q - 3'd1);
								mode_n      = M_NORMAL;
								seq_count_n = '0;
							end
						end
					end
				end
				default: begin
					// normal text, also any stray mode code
					mode_n = M_NORMAL;
					if (in_byte == 8'h22) begin
						fin      = 1'b1;
						fin_code = ST_CLOSED;
					end else if (in_byte < 8'h20) begin
						fin      = 1'b1;
						fin_code = ST_CONTROL_CHAR;
					end else if (in_byte == 8'h5C) begin
						mode_n = M_ESC;
					end else if (in_byte < 8'h80) begin
						has_bytes  = 1'b1;
						b.bytes[0] = in_byte;
					end else if (in_byte >= 8'hC2 && in_byte <= 8'hF4) begin
						if (in_byte <= 8'hDF) begin
							seq_length_n = 3'd2;
							code_accum_n = {16'd0, in_byte[4:0]};
						end else if (in_byte <= 8'hEF) begin
							seq_length_n = 3'd3;
							code_accum_n = {17'd0, in_byte[3:0]};
						end else begin
							seq_length_n = 3'd4;
							code_accum_n = {18'd0, in_byte[2:0]};
						end
						seq_we      = 1'b1;
						seq_widx    = 2'd0;
						seq_count_n = 3'd1;
						mode_n      = M_UTF8;
					end else begin
						fin      = 1'b1;
						fin_code = ST_BAD_UTF8;
					end
				end
			endcase
		end

		if (fin) begin
			b            = '0;
			b.is_stat    = 1'b1;
			b.stat       = fin_code;
			has_bytes    = 1'b0;
			mode_n       = M_NORMAL;
			hex_accum_n  = '0;
			hex_count_n  = '0;
			seq_count_n  = '0;
			seq_length_n = '0;
			code_accum_n = '0;
			seq_we       = 1'b0;
		end
	end

	assign bundle      = b;
	assign bundle_push = take && (fin || has_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_NORMAL;
			hex_accum_q  <= '0;
			hex_count_q  <= '0;
			seq_length_q <= '0;
			seq_count_q  <= '0;
			code_accum_q <= '0;
		end else if (take) begin
			mode_q       <= mode_n;
			hex_accum_q  <= hex_accum_n;
			hex_count_q  <= hex_count_n;
			seq_length_q <= seq_length_n;
			seq_count_q  <= seq_count_n;
			code_accum_q <= code_accum_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			high_half_q <= high_half_n;
			if (seq_we) seq_bytes_q[seq_widx] <= in_byte;
		end
	end

endmodule

// ===== design/jsu_queue.sv =====
// Small bundle queue between the scanner and the result sequencer.
// Holds QUEUE_DEPTH bundles; depth is a power of two.
// Depends on jsu_pkg.
module jsu_queue
	import jsu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	output logic    q_full,
	input  logic    rd_en,
	output bundle_t rd_data,
	output logic    q_avail
);

	bundle_t           slots_q [QUEUE_DEPTH];
	logic [QIDX_W:0]   wptr_q;
	logic [QIDX_W:0]   rptr_q;

	assign q_full  = (wptr_q[QIDX_W] != rptr_q[QIDX_W]) &&
	                 (wptr_q[QIDX_W-1:0] == rptr_q[QIDX_W-1:0]);
	assign q_avail = (wptr_q != rptr_q);
	assign rd_data = slots_q[rptr_q[QIDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr_en) wptr_q <= wptr_q + 1'b1;
			if (rd_en) rptr_q <= rptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slots_q[wptr_q[QIDX_W-1:0]] <= wr_data;
	end

endmodule

// ===== design/jsu_back.sv =====
// Result sequencer: takes bundles from the queue and presents their results
// one per transfer on the output queue interface. Depends on jsu_pkg.
module jsu_back
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_avail,
	input  bundle_t    q_data,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       last,
	output logic [3:0] status
);

	logic       head_valid_q;
	bundle_t    head_q;
	logic [1:0] idx_q;
	logic       head_last;
	logic       xfer;

	assign head_last  = head_q.is_stat || (idx_q == head_q.cnt_m1);
	assign xfer       = pop && head_valid_q;
	assign q_rd       = q_avail && (!head_valid_q || (xfer && head_last));

	assign empty      = !head_valid_q;
	assign data_byte  = head_q.is_stat ? 8'd0 : head_q.bytes[idx_q];
	assign byte_valid = !head_q.is_stat;
	assign last       = head_last;
	assign status     = head_q.is_stat ? head_q.stat : ST_RUNNING;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			idx_q        <= '0;
		end else if (q_rd) begin
			head_valid_q <= 1'b1;
			idx_q        <= '0;
		end else if (xfer) begin
			if (head_last) begin
				head_valid_q <= 1'b0;
				idx_q        <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) head_q <= q_data;
	end

endmodule

// ===== design/json_string_unescape_utf8_check.sv =====
// Top level of the JSON string unescape and UTF-8 check block.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
// Usage:
//   Input side behaves as a queue write port: present in_byte/end_of_text
//   with push high; a transfer happens on a rising edge where push is high
//   and full is low. Bytes are the body of one JSON string, starting after
//   the opening quote; end_of_text marks the end of the document.
//   Output side behaves as a queue read port: while empty is low the oldest
//   result sits on data_byte/byte_valid/last/status; pop high on a rising
//   edge transfers it. Each item gives no result, 1 to 4 decoded bytes
//   (status running) or one status result; last marks its final result.
//   Each result passes through the bundle queue and the output head register
//   before it can be popped. Throughput: one input item per cycle while full
//   is low; an item with N results holds the output for N transfers, and full
//   rises only once four bundles wait behind the one being popped.
//   Reset (arst_n low) empties the queue and returns the scanner to normal
//   text. A stalled receiver holds the current result steady; the scanner
//   keeps accepting until the queue fills.
module json_string_unescape_utf8_check
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       last,
	output logic [3:0] status
);

	logic    take;
	logic    bundle_push;
	bundle_t bundle;
	logic    q_full;
	logic    q_avail;
	logic    q_rd;
	bundle_t q_data;

	// accept an item whenever the bundle queue has room
	assign full = q_full;
	assign take = push && !q_full;

	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.bundle_push (bundle_push),
		.bundle      (bundle)
	);

	jsu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bundle_push),
		.wr_data (bundle),
		.q_full  (q_full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.q_avail (q_avail)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.status     (status)
	);

endmodule
